// ----- rtl/fpfa_pkg.sv -----
package fpfa_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int ACT_W      = 5;
    localparam int POL_W      = 2;
    localparam int SLOT_W     = 4;
    localparam int GRANT_W    = 4;
    localparam int RES_W      = 2;
    localparam int CMP_W      = ((IDX_W > ACT_W) ? IDX_W : ACT_W) + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = 5;

    // slave word: block_slot, size_value, zero fill to whole bytes
    localparam int IN_FIELDS_W = SLOT_W + 16;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((GRANT_W + 7) / 8) * 8;

    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    localparam logic [RES_W-1:0] RES_LOADED = 2'd0;
    localparam logic [RES_W-1:0] RES_ALLOC  = 2'd1;
    localparam logic [RES_W-1:0] RES_NOFIT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BLOCKS = 1'd1;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

    // search token walking down the cell row
    typedef struct packed {
        logic                 valid;
        logic [SIZE_BITS-1:0] want;
        logic                 found;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] size;
    } t_token;

    // broadcast update to every cell
    typedef struct packed {
        logic                 load_en;
        logic [SLOT_W-1:0]    load_idx;
        logic [SIZE_BITS-1:0] load_size;
        logic                 set_en;
        logic [IDX_W-1:0]     set_idx;
        logic                 clear_all;
    } t_cell_cmd;

endpackage

// ----- rtl/fpfa_cell.sv -----
module fpfa_cell
    import fpfa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [POL_W-1:0] i_policy,
    input  logic [ACT_W-1:0] i_active,
    input  t_cell_cmd        i_cmd,
    input  t_token           i_tok,
    output t_token           o_tok
);

    logic [SIZE_BITS-1:0] r_size;
    logic                 r_occ;
    t_token               r_tok;
    t_token               n_tok;
    logic                 eligible;
    logic                 take;
    logic                 in_range;

    assign in_range = CMP_W'(i_idx) < CMP_W'(i_active);
    assign eligible = i_tok.valid && !r_occ && (r_size >= i_tok.want) && in_range;

    // first fit (and the unused code) only takes when nothing is held yet
    always_comb begin
        take = 1'b0;
        if (eligible) begin
            if (!i_tok.found) begin
                take = 1'b1;
            end else if (i_policy == POL_BEST) begin
                take = r_size < i_tok.size;
            end else if (i_policy == POL_WORST) begin
                take = r_size > i_tok.size;
            end
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (take) begin
            n_tok.found = 1'b1;
            n_tok.idx   = i_idx;
            n_tok.size  = r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en && (CMP_W'(i_cmd.load_idx) == CMP_W'(i_idx))) begin
            r_size <= i_cmd.load_size;
        end
    end

    // batch end clear wins over the grant mark of the same item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_cmd.clear_all) begin
            r_occ <= 1'b0;
        end else if (i_cmd.load_en && (CMP_W'(i_cmd.load_idx) == CMP_W'(i_idx))) begin
            r_occ <= 1'b0;
        end else if (i_cmd.set_en && (i_cmd.set_idx == i_idx)) begin
            r_occ <= 1'b1;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- rtl/fixed_partition_fit_allocator_core.sv -----
// Fixed-partition fit allocator. Each of the 16 partitions lives in its own cell
// (size plus occupied mark), and the cells form a row. A load word writes one
// partition size and frees that partition. An allocate word launches a search
// token into cell 0; the token steps one cell per clock, each cell comparing
// its own size against the request and the best candidate so far (first,
// best or worst fit, lowest index on ties). When the token leaves the last
// cell the winner is marked occupied, an allocate word with batch_end clears
// all marks, and the result is registered. Only one word is in flight at a
// time. The output register lets a new word be taken while the previous
// result waits on the master side. Configuration is to be written only while
// idle; the user must keep to this, as the block does not enforce it.
// active_blocks above 16 acts as 16 and 0 gives no fit.
module fixed_partition_fit_allocator_core
    import fpfa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // request stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [3:0] block_slot, [19:4] size_value, rest 0
    input  logic                  i_s_axis_tuser,   // [0] req_type
    input  logic                  i_s_axis_tlast,   // batch_end
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [3:0] granted_block, rest 0
    output logic [RES_W-1:0]      o_m_axis_tuser    // [1:0] result_code
);

    // config registers
    logic [POL_W-1:0] r_cfg_policy;
    logic [ACT_W-1:0] r_cfg_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_policy <= POL_FIRST;
            r_cfg_active <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIT_POLICY:    r_cfg_policy <= i_cfg_data[POL_W-1:0];
                CFG_ACTIVE_BLOCKS: r_cfg_active <= i_cfg_data[ACT_W-1:0];
                default: ;
            endcase
        end
    end

    // input word unpack
    logic [SLOT_W-1:0]    in_slot;
    logic [SIZE_BITS-1:0] in_size;
    assign in_slot = i_s_axis_tdata[SLOT_W-1:0];
    assign in_size = SIZE_BITS'(i_s_axis_tdata[SLOT_W+15:SLOT_W]);

    t_state r_state;
    t_state n_state;

    logic acc;
    logic acc_load;
    logic acc_alloc;
    assign acc       = i_s_axis_tvalid && o_s_axis_tready;
    assign acc_load  = acc && (i_s_axis_tuser == REQ_LOAD);
    assign acc_alloc = acc && (i_s_axis_tuser == REQ_ALLOC);

    // cell row
    t_token    tok [0:NUM_BLOCKS];
    t_cell_cmd cmd;
    logic [NUM_BLOCKS-1:0] tok_live;

    for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
        fpfa_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (IDX_W'(k)),
            .i_policy (r_cfg_policy),
            .i_active (r_cfg_active),
            .i_cmd    (cmd),
            .i_tok    (tok[k]),
            .o_tok    (tok[k+1])
        );
        assign tok_live[k] = tok[k+1].valid;
    end

    t_token tok_last;
    assign tok_last = tok[NUM_BLOCKS];

    logic r_batch_end;
    always_ff @(posedge i_clk) begin
        if (acc_alloc) begin
            r_batch_end <= i_s_axis_tlast;
        end
    end

    // result of the current word
    logic               scan_done;
    logic               res_ev;
    logic [RES_W-1:0]   res_code;
    logic [GRANT_W-1:0] res_blk;

    assign scan_done = (r_state == ST_SCAN) && tok_last.valid;
    assign res_ev    = acc_load || scan_done;

    always_comb begin
        res_code = RES_LOADED;
        res_blk  = '0;
        if (scan_done) begin
            if (tok_last.found) begin
                res_code = RES_ALLOC;
                res_blk  = GRANT_W'(tok_last.idx);
            end else begin
                res_code = RES_NOFIT;
            end
        end
    end

    // output register plus one hold slot
    logic               r_out_valid;
    logic [RES_W-1:0]   r_out_code;
    logic [GRANT_W-1:0] r_out_blk;
    logic [RES_W-1:0]   r_hold_code;
    logic [GRANT_W-1:0] r_hold_blk;
    logic               out_free;

    assign out_free = !r_out_valid || i_m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_load) begin
                    n_state = out_free ? ST_IDLE : ST_HOLD;
                end else if (acc_alloc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tok_last.valid) begin
                    n_state = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs: handshake, token launch, cell commands
    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);

        tok[0].valid = acc_alloc;
        tok[0].want  = in_size;
        tok[0].found = 1'b0;
        tok[0].idx   = '0;
        tok[0].size  = '0;

        cmd.load_en   = acc_load;
        cmd.load_idx  = in_slot;
        cmd.load_size = in_size;
        cmd.set_en    = scan_done && tok_last.found;
        cmd.set_idx   = tok_last.idx;
        cmd.clear_all = scan_done && r_batch_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ev && !out_free) begin
            r_hold_code <= res_code;
            r_hold_blk  <= res_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free && (r_state == ST_HOLD || res_ev)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_state == ST_HOLD) begin
            r_out_code <= r_hold_code;
            r_out_blk  <= r_hold_blk;
        end else if (out_free && res_ev) begin
            r_out_code <= res_code;
            r_out_blk  <= res_blk;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out_blk);
    assign o_m_axis_tuser  = r_out_code;

    // checks
    a_token_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok_live != '0) |-> (r_state == ST_SCAN))
        else $error("search token alive outside scan");

    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_live))
        else $error("more than one search token in the row");

    a_hold_needs_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD) |-> r_out_valid)
        else $error("held result while output register empty");

    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan_done && tok_last.found) |-> (CMP_W'(tok_last.idx) < CMP_W'(r_cfg_active)))
        else $error("granted partition beyond active range");

endmodule
